// File: rtl/sm3_hash_engine_core_assert.svh
// assertion macros for the sm3 hash engine
`ifndef SM3_HASH_ENGINE_CORE_ASSERT_SVH
`define SM3_HASH_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SM3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SM3_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SM3_ASSERT(label, prop, msg)
`define SM3_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// File: rtl/sm3_pkg.sv
// shared types, constants and functions of the sm3 hash engine
package sm3_pkg;

    typedef logic [7:0][31:0] sm3_words_t;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } sm3_msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sm3_digest_t;

    typedef struct packed {
        logic push;
        logic load;
        logic round;
    } sm3_ctl_t;

    localparam logic [31:0] SM3_T_LOW  = 32'h79CC4519;
    localparam logic [31:0] SM3_T_HIGH = 32'h7A879D8A;
    localparam logic [31:0] SM3_PAD_WORD = 32'h80000000;

    // word 0 is A, word 7 is H
    localparam sm3_words_t SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    function automatic logic [31:0] sm3_rotl(logic [31:0] x, logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] sm3_p0(logic [31:0] x);
        return x ^ sm3_rotl(x, 5'd9) ^ sm3_rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] sm3_p1(logic [31:0] x);
        return x ^ sm3_rotl(x, 5'd15) ^ sm3_rotl(x, 5'd23);
    endfunction

    // round constant rotated by the round number
    function automatic logic [31:0] sm3_tj(logic [5:0] r);
        logic [31:0] t;
        t = (r < 6'd16) ? SM3_T_LOW : SM3_T_HIGH;
        return sm3_rotl(t, r[4:0]);
    endfunction

endpackage

// File: rtl/sm3_if.sv
// handshake channels for message words and digest words
interface sm3_msg_if
    import sm3_pkg::*;
();
    logic     valid;
    logic     ready;
    sm3_msg_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sm3_digest_if
    import sm3_pkg::*;
();
    logic        valid;
    logic        ready;
    sm3_digest_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sm3_hash_engine_core.sv
// sm3 hash engine top level: word intake, padding, round sequencer and digest output
// a message word is taken only while the sequencer is idle; each full block then goes
// through working load, 64 rounds on the shared round unit and chaining fold, and
// no further message word is taken until that block is through
// the last word adds padding words, one or two block compressions and
// 8 digest words through an output register; rst_n clears control and sets the iv
`include "sm3_hash_engine_core_assert.svh"

module sm3_hash_engine_core
    import sm3_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sm3_msg_if.sink             msg_in,
    sm3_digest_if.source        digest_out
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  fill_reg, fill_next;        // words held in the block
    logic [5:0]  round_reg, round_next;
    logic [63:0] bitcnt_reg, bitcnt_next;    // message length in bits, wraps
    sm3_words_t  cv_reg, cv_next;            // chaining value
    logic        pad_reg, pad_next;          // padding the final block(s)
    logic        pad80_reg, pad80_next;      // a whole 0x80 word still owed
    logic        hi_done_reg, hi_done_next;  // upper length word pushed
    logic        final_reg, final_next;      // lower length word pushed
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_valid_reg, out_valid_next;
    sm3_digest_t out_data_reg, out_data_next;

    sm3_ctl_t    ctl;
    logic [31:0] push_word;
    sm3_words_t  work;

    logic        accept;
    logic        full_word;
    logic [31:0] merged_word;
    logic [5:0]  add_bits;
    logic        out_load;

    assign msg_in.ready = (state_reg == ST_IDLE);
    assign accept       = msg_in.valid && msg_in.ready;
    assign full_word    = (msg_in.data.valid_bytes >= 3'd4);
    assign out_load     = (state_reg == ST_OUT) && (!out_valid_reg || digest_out.ready);

    // short last word: keep the valid bytes and append the 0x80 marker
    always_comb
    begin
        case (msg_in.data.valid_bytes[1:0])
            2'd0:    merged_word = SM3_PAD_WORD;
            2'd1:    merged_word = {msg_in.data.message_word[31:24], 24'h800000};
            2'd2:    merged_word = {msg_in.data.message_word[31:16], 16'h8000};
            default: merged_word = {msg_in.data.message_word[31:8], 8'h80};
        endcase
        if (msg_in.data.last && !full_word)
        begin
            add_bits = {1'b0, msg_in.data.valid_bytes[1:0], 3'b000};
        end
        else
        begin
            add_bits = 6'd32;
        end
    end

    // which word goes into the block this cycle
    always_comb
    begin
        ctl.push  = 1'b0;
        ctl.load  = (state_reg == ST_LOAD);
        ctl.round = (state_reg == ST_ROUND);
        push_word = msg_in.data.message_word;
        if (state_reg == ST_IDLE)
        begin
            ctl.push = accept;
            if (msg_in.data.last && !full_word)
            begin
                push_word = merged_word;
            end
        end
        else if (state_reg == ST_PAD)
        begin
            ctl.push = 1'b1;
            if (pad80_reg)
            begin
                push_word = SM3_PAD_WORD;
            end
            else if (hi_done_reg)
            begin
                push_word = bitcnt_reg[31:0];
            end
            else if (fill_reg == 4'd14)
            begin
                push_word = bitcnt_reg[63:32];
            end
            else
            begin
                push_word = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        bitcnt_next    = bitcnt_reg;
        cv_next        = cv_reg;
        pad_next       = pad_reg;
        pad80_next     = pad80_reg;
        hi_done_next   = hi_done_reg;
        final_next     = final_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (digest_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bitcnt_next = bitcnt_reg + 64'(add_bits);
                    fill_next   = fill_reg + 4'd1;
                    if (msg_in.data.last)
                    begin
                        pad_next   = 1'b1;
                        pad80_next = full_word;
                    end
                    if (fill_reg == 4'd15)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (msg_in.data.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                fill_next = fill_reg + 4'd1;
                if (pad80_reg)
                begin
                    pad80_next = 1'b0;
                end
                else if (hi_done_reg)
                begin
                    final_next = 1'b1;
                end
                else if (fill_reg == 4'd14)
                begin
                    hi_done_next = 1'b1;
                end
                if (fill_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    cv_next[k] = cv_reg[k] ^ work[k];
                end
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.digest_word = cv_reg[out_idx_reg];
                    out_data_next.word_index  = out_idx_reg;
                    out_data_next.last_word   = (out_idx_reg == 3'd7);
                    out_idx_next              = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        // digest is in the output register: back to reset state
                        cv_next      = SM3_IV;
                        bitcnt_next  = '0;
                        pad_next     = 1'b0;
                        pad80_next   = 1'b0;
                        hi_done_next = 1'b0;
                        final_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            round_reg     <= '0;
            bitcnt_reg    <= '0;
            cv_reg        <= SM3_IV;
            pad_reg       <= 1'b0;
            pad80_reg     <= 1'b0;
            hi_done_reg   <= 1'b0;
            final_reg     <= 1'b0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            bitcnt_reg    <= bitcnt_next;
            cv_reg        <= cv_next;
            pad_reg       <= pad_next;
            pad80_reg     <= pad80_next;
            hi_done_reg   <= hi_done_next;
            final_reg     <= final_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign digest_out.valid = out_valid_reg;
    assign digest_out.data  = out_data_reg;

    // shared round unit holds the message window and the working words
    sm3_round_unit u_round (
        .clk       (clk),
        .ctl       (ctl),
        .push_word (push_word),
        .round_idx (round_reg),
        .cv        (cv_reg),
        .work      (work)
    );

    `SM3_ASSERT(a_load_on_full_block, (state_reg == ST_LOAD) |-> (fill_reg == 4'd0), "block compressed before it was full")
    `SM3_ASSERT(a_round_count_parked, (state_reg != ST_ROUND) |-> (round_reg == 6'd0), "round counter not back at zero")
    `SM3_ASSERT(a_pad_needs_last, (state_reg == ST_PAD) |-> pad_reg, "padding without a last word")
    `SM3_ASSERT_NEVER(a_pad_order, pad80_reg && (hi_done_reg || final_reg), "length pushed before the pad marker")
    `SM3_ASSERT(a_digest_end_reset, (out_load && (out_idx_reg == 3'd7)) |=> ((state_reg == ST_IDLE) && (cv_reg == SM3_IV) && (bitcnt_reg == 64'd0)), "state not reset after the digest")
    `SM3_ASSERT(a_last_word_flag, digest_out.valid |-> (digest_out.data.last_word == (digest_out.data.word_index == 3'd7)), "last word flag and index disagree")

endmodule

// File: rtl/sm3_round_unit.sv
// message window with on-the-fly expansion and the shared compression round
module sm3_round_unit
    import sm3_pkg::*;
(
    input  logic        clk,
    input  sm3_ctl_t    ctl,
    input  logic [31:0] push_word,
    input  logic [5:0]  round_idx,
    input  sm3_words_t  cv,
    output sm3_words_t  work
);

    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    sm3_words_t  work_reg;
    sm3_words_t  work_next;

    logic [31:0] w_new;
    logic [31:0] a12;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] tt1;
    logic [31:0] tt2;

    // window holds w[j] .. w[j+15]
    always_comb
    begin
        w_new = sm3_p1(win_reg[0] ^ win_reg[7] ^ sm3_rotl(win_reg[13], 5'd15))
              ^ sm3_rotl(win_reg[3], 5'd7) ^ win_reg[10];
        for (int i = 0; i < 15; i++)
        begin
            win_next[i] = (ctl.push || ctl.round) ? win_reg[i + 1] : win_reg[i];
        end
        if (ctl.push)
        begin
            win_next[15] = push_word;
        end
        else if (ctl.round)
        begin
            win_next[15] = w_new;
        end
        else
        begin
            win_next[15] = win_reg[15];
        end
    end

    always_comb
    begin
        a12 = sm3_rotl(work_reg[0], 5'd12);
        ss1 = sm3_rotl(a12 + work_reg[4] + sm3_tj(round_idx), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_idx < 6'd16)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
               | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + work_reg[7] + ss1 + win_reg[0];

        work_next = work_reg;
        if (ctl.load)
        begin
            work_next = cv;
        end
        else if (ctl.round)
        begin
            work_next[0] = tt1;
            work_next[1] = work_reg[0];
            work_next[2] = sm3_rotl(work_reg[1], 5'd9);
            work_next[3] = work_reg[2];
            work_next[4] = sm3_p0(tt2);
            work_next[5] = work_reg[4];
            work_next[6] = sm3_rotl(work_reg[5], 5'd19);
            work_next[7] = work_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule

// File: bench/sm3_hash_engine_core_tb.sv
// self-checking bench for the sm3 hash engine: message words in, digest words checked
module sm3_hash_engine_core_tb
    import sm3_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 8;
    localparam int LONG_HOLD    = 400;   // receiver hold-off that backs the engine up
    localparam int STALL_LIMIT  = 4000;  // cycles with no word moving before giving up
    localparam int SETTLE       = 150;   // quiet cycles after the last digest word
    localparam int RANDOM_ITEMS = 110;
    localparam int QUIET_AFTER  = 104;   // random words after which nobody idles

    // digest predictor: a bit-exact sm3 of its own plus the queue of digest
    // words still owed by the engine
    class sm3_digest_board;
        localparam logic [31:0] T_LOW   = 32'h79CC4519;
        localparam logic [31:0] T_HIGH  = 32'h7A879D8A;
        localparam logic [31:0] PAD     = 32'h00000080;

        logic [31:0] chain [8];
        logic [31:0] block_words [16];
        int          fill;
        logic [63:0] bit_count;
        sm3_digest_t pending_digest [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
            fill      = 0;
            bit_count = '0;
        endfunction

        static function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress_block();
            logic [31:0] w [68];
            logic [31:0] a, b, c, d, e, f, g, h;
            logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, t, x;
            for (int j = 0; j < 16; j++)
                w[j] = block_words[j];
            for (int j = 16; j < 68; j++)
            begin
                x    = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
                w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
            end
            {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                        chain[4], chain[5], chain[6], chain[7]};
            for (int r = 0; r < 64; r++)
            begin
                t   = (r < 16) ? T_LOW : T_HIGH;
                a12 = rol(a, 12);
                ss1 = rol(a12 + e + rol(t, r % 32), 7);
                ss2 = ss1 ^ a12;
                if (r < 16)
                begin
                    ff = a ^ b ^ c;
                    gg = e ^ f ^ g;
                end
                else
                begin
                    ff = (a & b) | (a & c) | (b & c);
                    gg = (e & f) | (~e & g);
                end
                tt1 = ff + d + ss2 + (w[r] ^ w[r+4]);
                tt2 = gg + h + ss1 + w[r];
                d = c;
                c = rol(b, 9);
                b = a;
                a = tt1;
                h = g;
                g = rol(f, 19);
                f = e;
                e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
            end
            chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
            chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
        endfunction

        function void push(logic [31:0] w);
            block_words[fill] = w;
            fill++;
            if (fill == 16)
            begin
                compress_block();
                fill = 0;
            end
        endfunction

        // called for every accepted message word
        function void note_word(sm3_msg_t m);
            int          vb;
            logic [31:0] keep;
            sm3_digest_t dw;
            if (!m.last)
            begin
                bit_count += 64'd32;
                push(m.message_word);
                return;
            end
            vb = (m.valid_bytes > 3'd4) ? 4 : int'(m.valid_bytes);
            bit_count += 64'(8 * vb);
            if (vb == 4)
            begin
                push(m.message_word);
                push(PAD << 24);
            end
            else
            begin
                keep = (vb == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * vb));
                push((m.message_word & keep) | (PAD << (24 - 8 * vb)));
            end
            while (fill != 14)
                push(32'h0);
            push(bit_count[63:32]);
            push(bit_count[31:0]);
            for (int k = 0; k < 8; k++)
            begin
                dw.digest_word = chain[k];
                dw.word_index  = 3'(k);
                dw.last_word   = (k == 7);
                pending_digest.push_back(dw);
            end
            restart();
        endfunction

        // called for every accepted digest word
        function void check_digest(sm3_digest_t got);
            sm3_digest_t want;
            if (pending_digest.size() == 0)
            begin
                $error("digest word %h with none expected", got.digest_word);
                errors++;
                return;
            end
            want = pending_digest.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word: expected %b, got %b", want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sm3_msg_if    msg_in();
    sm3_digest_if digest_out();

    sm3_hash_engine_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .digest_out (digest_out)
    );

    sm3_digest_board board = new();

    int quiet_phase;    // set for the tail of the run: no idling on either side
    int hold_receiver;  // request for one long receiver hold-off
    int items_sent;

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // both monitors sample at the rising edge, before the edge's updates land
    always @(posedge clk)
        if (rst_n && msg_in.valid && msg_in.ready)
            board.note_word(msg_in.data);

    always @(posedge clk)
        if (rst_n && digest_out.valid && digest_out.ready)
            board.check_digest(digest_out.data);

    // watchdog: any word moving on either channel restarts the count
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (msg_in.valid && msg_in.ready) ||
            (digest_out.valid && digest_out.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: runs of readiness broken by short random stalls, and one long
    // hold-off on request so the engine backs up into its input
    initial
    begin
        digest_out.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            digest_out.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (hold_receiver != 0)
            begin
                digest_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_receiver = 0;
            end
            else if (quiet_phase == 0 && $urandom_range(0, 1) == 1)
            begin
                digest_out.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // offer one message word and wait for it to be taken; afterwards the sender
    // may idle for a burst, otherwise valid simply stays up for the next word
    task automatic send_word(input logic [31:0] w, input logic [2:0] vb,
                             input logic lst, input int gap_pct);
        sm3_msg_t m;
        m.message_word = w;
        m.valid_bytes  = vb;
        m.last         = lst;
        msg_in.data  <= m;
        msg_in.valid <= 1'b1;
        do
            @(posedge clk);
        while (!(msg_in.valid && msg_in.ready));
        items_sent++;
        if (quiet_phase == 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            msg_in.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // random content; non-last words sometimes carry a stray byte count,
    // which the engine must ignore
    task automatic send_random_message(input int n_words, input int gap_pct);
        logic [2:0] vb;
        for (int i = 0; i < n_words - 1; i++)
        begin
            vb = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word($urandom, vb, 1'b0, gap_pct);
        end
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, gap_pct);
    endtask

    // sender stands back until every owed digest word has come out
    task automatic wait_drained();
        msg_in.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_digest.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n_words;
        int gap_pct;
        int pick;
        int msg_count;

        quiet_phase   = 0;
        hold_receiver = 0;
        items_sent    = 0;
        msg_count     = 0;
        msg_in.valid  = 1'b0;
        msg_in.data   = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message with all bytes masked off
        send_word(32'hFFFFFFFF, 3'd0, 1'b1, 0);
        // "abc" with a junk trailing byte that must be cleared
        send_word(32'h616263FF, 3'd3, 1'b1, 0);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1, 0);
        send_word(32'h00000000, 3'd2, 1'b1, 0);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1, 0);
        // byte count above four on the last word counts as four
        send_word(32'h12345678, 3'd7, 1'b1, 0);
        // short count on a word that is not last is ignored
        send_word(32'hA5A5A5A5, 3'd2, 1'b0, 0);
        send_word(32'h5A5A5A5A, 3'd5, 1'b1, 0);
        // full last word at position 13: padding spills into a second block
        for (int i = 0; i < 13; i++)
            send_word((i % 2 == 0) ? 32'h00000000 : 32'hFFFFFFFF, 3'd4, 1'b0, 25);
        send_word(32'h80000001, 3'd4, 1'b1, 25);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet_phase = 1;
            if (msg_count == 3)
            begin
                // back-pressure: receiver holds while two messages are pushed
                // with no gaps, then the sender waits for a full drain
                hold_receiver = 1;
                send_random_message(20, 0);
                send_random_message(6, 0);
                wait_drained();
            end
            else
            begin
                // lengths cluster around the one-block/two-block padding boundary
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    n_words = $urandom_range(1, 12);
                else if (pick < 8)
                    n_words = $urandom_range(13, 17);
                else if (pick == 8)
                    n_words = $urandom_range(18, 34);
                else
                    n_words = 1;
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                send_random_message(n_words, gap_pct);
            end
            msg_count++;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0 && board.pending_digest.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sm3_pkg.sv
rtl/sm3_if.sv
rtl/sm3_round_unit.sv
rtl/sm3_hash_engine_core.sv
bench/sm3_hash_engine_core_tb.sv
